// ----- design/gsr_pkg.sv -----
// gsr_pkg: sizes, entry packing and status codes of the glyph set recorder
// used by the channel interfaces, the slot table and the top level
`default_nettype none

package gsr_pkg;

   localparam int MAX_FONTS       = 8;
   localparam int MAX_ENTRIES     = 512;
   localparam int STYLES_PER_FONT = 4;

   localparam int FONT_ID_W   = 32;
   localparam int STYLE_W     = 2;
   localparam int CODEPOINT_W = 21;
   localparam int STATUS_W    = 3;
   localparam int SLOT_OUT_W  = 3;
   localparam int GROUP_OUT_W = 5;
   localparam int TOTAL_W     = 10;
   localparam int GC_W        = 10;

   localparam int SLOT_W      = (MAX_FONTS > 1) ? $clog2(MAX_FONTS) : 1;
   localparam int SLOT_CNT_W  = $clog2(MAX_FONTS + 1);
   localparam int GROUP_COUNT = MAX_FONTS * STYLES_PER_FONT;
   localparam int GROUP_W     = SLOT_W + STYLE_W;
   localparam int ENTRY_W     = CODEPOINT_W + STYLE_W + SLOT_W;
   localparam int ENTRY_IDX_W = $clog2(MAX_ENTRIES);
   localparam int ENTRY_CNT_W = $clog2(MAX_ENTRIES + 1);

   typedef enum logic [STATUS_W-1:0] {
      ST_ADDED     = 3'd0,
      ST_DUPLICATE = 3'd1,
      ST_CAP_DROP  = 3'd2,
      ST_FONT_FULL = 3'd3,
      ST_CLEARED   = 3'd4
   } status_type;

   typedef struct packed {
      logic              hit;
      logic              full;
      logic [SLOT_W-1:0] slot;
   } slot_lookup_type;

endpackage

`default_nettype wire

// ----- design/gsr_if.sv -----
// gsr_if: valid/ready channel interfaces for request and response transactions
// depends on gsr_pkg for field widths
`default_nettype none

interface gsr_req_if
   import gsr_pkg::*;
;
   logic                   valid;
   logic                   ready;
   logic                   command;
   logic [FONT_ID_W-1:0]   font_id;
   logic [STYLE_W-1:0]     style;
   logic [CODEPOINT_W-1:0] codepoint;

   modport source (output valid, command, font_id, style, codepoint, input ready);
   modport sink   (input valid, command, font_id, style, codepoint, output ready);
endinterface

interface gsr_rsp_if
   import gsr_pkg::*;
;
   logic                   valid;
   logic                   ready;
   logic [STATUS_W-1:0]    status;
   logic [SLOT_OUT_W-1:0]  font_slot;
   logic [GROUP_OUT_W-1:0] group;
   logic [TOTAL_W-1:0]     entry_total;
   logic                   overflow_seen;

   modport source (output valid, status, font_slot, group, entry_total, overflow_seen,
                   input ready);
   modport sink   (input valid, status, font_slot, group, entry_total, overflow_seen,
                   output ready);
endinterface

`default_nettype wire

// ----- design/gsr_slot_table.sv -----
// gsr_slot_table: font id to slot table with parallel lookup and in-order allocation
// depends on gsr_pkg
`default_nettype none

module gsr_slot_table
   import gsr_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 clear,
   input  wire logic                 alloc,
   input  wire logic [FONT_ID_W-1:0] font_id,
   output slot_lookup_type           lookup
);

   logic [FONT_ID_W-1:0]  ids_ff [MAX_FONTS];
   logic [SLOT_CNT_W-1:0] count_ff;
   logic [MAX_FONTS-1:0]  match;

   always_comb begin
      for (int i = 0; i < MAX_FONTS; i++) begin
         match[i] = (SLOT_CNT_W'(i) < count_ff) && (ids_ff[i] == font_id);
      end
      lookup.hit  = |match;
      lookup.slot = count_ff[SLOT_W-1:0];
      // lowest matching slot wins
      for (int i = MAX_FONTS - 1; i >= 0; i--) begin
         if (match[i]) begin
            lookup.slot = SLOT_W'(i);
         end
      end
      lookup.full = !lookup.hit && (count_ff >= SLOT_CNT_W'(MAX_FONTS));
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         count_ff <= '0;
      end else if (alloc) begin
         count_ff <= count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (alloc) begin
         ids_ff[count_ff[SLOT_W-1:0]] <= font_id;
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= SLOT_CNT_W'(MAX_FONTS))
      else $error("slot count beyond table size");

   a_alloc_not_full: assert property (@(posedge clock) disable iff (reset)
      alloc |-> !lookup.full && !lookup.hit)
      else $error("slot allocated on hit or full table");

   a_alloc_grows: assert property (@(posedge clock) disable iff (reset)
      alloc && !clear |=> count_ff == $past(count_ff) + 1'b1)
      else $error("allocation did not advance slot count");
`endif

endmodule

`default_nettype wire

// ----- design/glyph_set_recorder.sv -----
// glyph_set_recorder: records unique (font slot, style, codepoint) entries
// a clear or font-table-full request goes straight to S_DONE; a record first searches the stored entries
// throughput: one transaction at a time, each record held for the linear walk of
// the entry memory at one read per cycle
// reset: synchronous, empties slot table, entry set, group counters and overflow flag
`default_nettype none

module glyph_set_recorder
   import gsr_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   gsr_req_if.sink   req_ch,
   gsr_rsp_if.source rsp_ch
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SEARCH,
      S_DONE
   } state_type;

   state_type              state_ff;
   logic [ENTRY_W-1:0]     packed_ff;
   logic [GROUP_W-1:0]     grp_ff;
   logic [ENTRY_CNT_W-1:0] addr_ff;
   logic                   pend_ff;
   logic [ENTRY_CNT_W-1:0] entry_count_ff;
   logic                   cap_ff;
   logic [GROUP_COUNT-1:0] gc_valid_ff;
   status_type             res_status_ff;
   logic [SLOT_W-1:0]      res_slot_ff;
   logic [GROUP_W-1:0]     res_grp_ff;

   logic                   rsp_valid_ff;
   logic [STATUS_W-1:0]    rsp_status_ff;
   logic [SLOT_OUT_W-1:0]  rsp_slot_ff;
   logic [GROUP_OUT_W-1:0] rsp_group_ff;
   logic [TOTAL_W-1:0]     rsp_total_ff;
   logic                   rsp_overflow_ff;

   logic [ENTRY_W-1:0]     entry_mem [MAX_ENTRIES];
   logic [ENTRY_W-1:0]     entry_rd_ff;
   logic [GC_W-1:0]        gc_mem [GROUP_COUNT];
   logic [GC_W-1:0]        gc_rd_ff;

   slot_lookup_type        lookup;
   logic                   accept;
   logic                   clear_en;
   logic                   alloc_en;
   logic                   record_go;
   logic [GROUP_W-1:0]     req_grp;
   logic                   hit_now;
   logic                   walk_end;
   logic                   ent_wr;
   logic                   ent_rd;
   logic                   at_cap;
   logic                   out_free;
   logic [SLOT_W+SLOT_OUT_W-1:0]   slot_wide;
   logic [GROUP_W+GROUP_OUT_W-1:0] grp_wide;
   logic [ENTRY_CNT_W+TOTAL_W-1:0] total_wide;

   gsr_slot_table u_slots (
      .clock   (clock),
      .reset   (reset),
      .clear   (clear_en),
      .alloc   (alloc_en),
      .font_id (req_ch.font_id),
      .lookup  (lookup)
   );

   always_comb begin
      accept    = req_ch.valid && req_ch.ready;
      clear_en  = accept && !req_ch.command;
      record_go = accept && req_ch.command && !lookup.full;
      alloc_en  = record_go && !lookup.hit;
      req_grp   = {lookup.slot, req_ch.style};
      hit_now   = pend_ff && (entry_rd_ff == packed_ff);
      walk_end  = (state_ff == S_SEARCH) && !hit_now && (addr_ff == entry_count_ff);
      at_cap    = entry_count_ff >= ENTRY_CNT_W'(MAX_ENTRIES);
      ent_wr    = walk_end && !at_cap;
      ent_rd    = (state_ff == S_SEARCH) && !hit_now && (addr_ff != entry_count_ff);
      out_free  = !rsp_valid_ff || rsp_ch.ready;
      slot_wide  = {{SLOT_OUT_W{1'b0}}, res_slot_ff};
      grp_wide   = {{GROUP_OUT_W{1'b0}}, res_grp_ff};
      total_wide = {{TOTAL_W{1'b0}}, entry_count_ff};
   end

   assign req_ch.ready         = (state_ff == S_IDLE);
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.status        = rsp_status_ff;
   assign rsp_ch.font_slot     = rsp_slot_ff;
   assign rsp_ch.group         = rsp_group_ff;
   assign rsp_ch.entry_total   = rsp_total_ff;
   assign rsp_ch.overflow_seen = rsp_overflow_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         pend_ff        <= 1'b0;
         entry_count_ff <= '0;
         cap_ff         <= 1'b0;
         gc_valid_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         // in S_DONE the output register is reloaded instead
         if (rsp_valid_ff && rsp_ch.ready && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (clear_en) begin
                  entry_count_ff <= '0;
                  cap_ff         <= 1'b0;
                  gc_valid_ff    <= '0;
                  res_status_ff  <= ST_CLEARED;
                  res_slot_ff    <= '0;
                  res_grp_ff     <= '0;
                  state_ff       <= S_DONE;
               end else if (accept && lookup.full) begin
                  res_status_ff <= ST_FONT_FULL;
                  res_slot_ff   <= '0;
                  res_grp_ff    <= '0;
                  state_ff      <= S_DONE;
               end else if (record_go) begin
                  packed_ff   <= {lookup.slot, req_ch.style, req_ch.codepoint};
                  grp_ff      <= req_grp;
                  res_slot_ff <= lookup.slot;
                  res_grp_ff  <= req_grp;
                  addr_ff     <= '0;
                  pend_ff     <= 1'b0;
                  state_ff    <= S_SEARCH;
               end
            end
            S_SEARCH: begin
               if (hit_now) begin
                  pend_ff       <= 1'b0;
                  res_status_ff <= ST_DUPLICATE;
                  state_ff      <= S_DONE;
               end else if (walk_end) begin
                  pend_ff  <= 1'b0;
                  state_ff <= S_DONE;
                  if (at_cap) begin
                     cap_ff        <= 1'b1;
                     res_status_ff <= ST_CAP_DROP;
                  end else begin
                     entry_count_ff      <= entry_count_ff + 1'b1;
                     gc_valid_ff[grp_ff] <= 1'b1;
                     res_status_ff       <= ST_ADDED;
                  end
               end else begin
                  // read of addr_ff issued now, compared next cycle
                  pend_ff <= 1'b1;
                  addr_ff <= addr_ff + 1'b1;
               end
            end
            S_DONE: begin
               if (out_free) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_status_ff   <= res_status_ff;
                  rsp_slot_ff     <= slot_wide[SLOT_OUT_W-1:0];
                  rsp_group_ff    <= grp_wide[GROUP_OUT_W-1:0];
                  rsp_total_ff    <= total_wide[TOTAL_W-1:0];
                  rsp_overflow_ff <= cap_ff;
                  state_ff        <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // entry set memory, one read or one write per cycle
   always_ff @(posedge clock) begin
      if (ent_wr) begin
         entry_mem[entry_count_ff[ENTRY_IDX_W-1:0]] <= packed_ff;
      end
      if (ent_rd) begin
         entry_rd_ff <= entry_mem[addr_ff[ENTRY_IDX_W-1:0]];
      end
   end

   // group counters: read when a record is accepted, written back on insert
   always_ff @(posedge clock) begin
      if (record_go) begin
         gc_rd_ff <= gc_mem[req_grp];
      end
      if (ent_wr) begin
         gc_mem[grp_ff] <= (gc_valid_ff[grp_ff] ? gc_rd_ff : GC_W'(0)) + 1'b1;
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      entry_count_ff <= ENTRY_CNT_W'(MAX_ENTRIES))
      else $error("entry count beyond capacity");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SEARCH |-> addr_ff <= entry_count_ff)
      else $error("search address passed entry count");

   a_cap_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(cap_ff) |-> entry_count_ff == ENTRY_CNT_W'(MAX_ENTRIES))
      else $error("overflow flag raised below capacity");

   a_insert_once: assert property (@(posedge clock) disable iff (reset)
      ent_wr |=> state_ff == S_DONE && entry_count_ff == $past(entry_count_ff) + 1'b1)
      else $error("insert did not advance entry count");

   a_pend_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_SEARCH |-> !pend_ff)
      else $error("read pending outside search");
`endif

endmodule

`default_nettype wire
